// ----- sv/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 6;
  localparam int LEN_W            = 6;
  localparam int OP_W             = 3;
  localparam int STATUS_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_LD
  } state_t;

endpackage

// ----- sv/ple_ram.sv -----
// ----------------------------------------------------------------------------
// Positional list engine RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed values with positional insert, delete and
// dump, kept in a RAM and reordered by a shared move sequencer.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_ready, op, position, value   into the block
//   out      out_valid, out_ready, item, has_item,     out of the block
//            list_length, status, last
//
// An insert or delete moves the affected entries one per cycle through the
// RAM's read and write ports, then writes the new value (for an insert)
// and updates the count. A dump reads each entry through the registered
// RAM read port before loading it to the output; a dump of an empty list
// gives a single response with no item. A rejected operation or an unused
// op code gives a single response with no RAM access.
// Reset empties the list at once; the RAM contents are not cleared.
// A stalled output holds the sequencer until its transfer completes.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ple_pkg::OP_W-1:0]             op,
  input  logic [ple_pkg::POS_W-1:0]            position,
  input  logic signed [ple_pkg::VALUE_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ple_pkg::VALUE_W-1:0]   item,
  output logic                                 has_item,
  output logic [ple_pkg::LEN_W-1:0]            list_length,
  output logic [ple_pkg::STATUS_W-1:0]         status,
  output logic                                 last
);

  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rem, rem_next;
  logic [AW-1:0]       raddr, raddr_next;
  logic [AW-1:0]       tgt, tgt_next;
  logic [AW-1:0]       waddr, waddr_next;
  logic [AW-1:0]       k, k_next;
  logic                ins_dir, ins_dir_next;
  logic                pend, pend_next;
  logic [VALUE_W-1:0]  held_value, held_value_next;
  status_t             resp_status, resp_status_next;

  logic                ram_wr_en, ram_rd_en;
  logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [VALUE_W-1:0]  ram_wr_data, ram_rd_data;

  logic                out_free, out_load, dump_last;
  logic [VALUE_W-1:0]  item_next;
  logic                has_item_next, last_next;
  status_t             status_next;

  logic [POS_W-1:0]    pos_idx;
  logic [XW-1:0]       idx_x, cnt_x, ins_tgt_x, del_tgt_x;
  logic                ins_ok, del_ok;

  ple_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign pos_idx   = (position == '0) ? '0 : position - POS_W'(1);
  assign idx_x     = XW'(pos_idx);
  assign cnt_x     = XW'(count);
  assign ins_ok    = (count != CW'(CAPACITY));
  assign out_free  = !out_valid || out_ready;
  assign dump_last = ((CW'(k) + CW'(1)) == count);

  always_comb begin
    case (op)
      OP_INS_FRONT: ins_tgt_x = '0;
      OP_INS_BACK:  ins_tgt_x = cnt_x;
      default:      ins_tgt_x = (idx_x > cnt_x) ? cnt_x : idx_x;
    endcase
    case (op)
      OP_DEL_FRONT: del_tgt_x = '0;
      OP_DEL_BACK:  del_tgt_x = cnt_x - XW'(1);
      default:      del_tgt_x = idx_x;
    endcase
    del_ok = (count != '0) && (del_tgt_x < cnt_x);
  end

  // Next state and sequencer registers.
  always_comb begin
    state_next       = state;
    count_next       = count;
    rem_next         = rem;
    raddr_next       = raddr;
    tgt_next         = tgt;
    waddr_next       = waddr;
    k_next           = k;
    ins_dir_next     = ins_dir;
    pend_next        = 1'b0;
    held_value_next  = held_value;
    resp_status_next = resp_status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              if (!ins_ok) begin
                resp_status_next = ST_FULL;
                state_next       = S_RESP;
              end else begin
                tgt_next        = AW'(ins_tgt_x);
                rem_next        = count - CW'(AW'(ins_tgt_x));
                raddr_next      = AW'(count - CW'(1));
                ins_dir_next    = 1'b1;
                held_value_next = value;
                state_next      = S_SHIFT;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
              if (!del_ok) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                tgt_next     = AW'(del_tgt_x);
                rem_next     = count - CW'(AW'(del_tgt_x)) - CW'(1);
                raddr_next   = AW'(del_tgt_x) + AW'(1);
                ins_dir_next = 1'b0;
                state_next   = S_SHIFT;
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                resp_status_next = ST_DONE;
                state_next       = S_RESP;
              end else begin
                k_next     = '0;
                state_next = S_DUMP_RD;
              end
            end
            default: begin
              resp_status_next = ST_DONE;
              state_next       = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (rem != '0) begin
          rem_next   = rem - CW'(1);
          pend_next  = 1'b1;
          waddr_next = ins_dir ? raddr + AW'(1) : raddr - AW'(1);
          raddr_next = ins_dir ? raddr - AW'(1) : raddr + AW'(1);
        end else if (!pend) begin
          count_next       = ins_dir ? count + CW'(1) : count - CW'(1);
          resp_status_next = ST_DONE;
          state_next       = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        state_next = S_DUMP_LD;
      end
      S_DUMP_LD: begin
        if (out_free) begin
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + AW'(1);
            state_next = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: RAM controls and result loading.
  always_comb begin
    in_ready      = (state == S_IDLE);
    ram_rd_en     = 1'b0;
    ram_rd_addr   = raddr;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = tgt;
    ram_wr_data   = held_value;
    out_load      = 1'b0;
    item_next     = '0;
    has_item_next = 1'b0;
    status_next   = resp_status;
    last_next     = 1'b1;
    case (state)
      S_SHIFT: begin
        ram_rd_en = (rem != '0);
        if (pend) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = waddr;
          ram_wr_data = ram_rd_data;
        end else if (rem == '0) begin
          ram_wr_en = ins_dir;
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      S_DUMP_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = k;
      end
      S_DUMP_LD: begin
        out_load      = out_free;
        item_next     = ram_rd_data;
        has_item_next = 1'b1;
        status_next   = ST_DONE;
        last_next     = dump_last;
      end
      default: begin
        in_ready = (state == S_IDLE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    rem         <= rem_next;
    raddr       <= raddr_next;
    tgt         <= tgt_next;
    waddr       <= waddr_next;
    k           <= k_next;
    ins_dir     <= ins_dir_next;
    held_value  <= held_value_next;
    resp_status <= resp_status_next;
    if (out_load) begin
      item        <= $signed(item_next);
      has_item    <= has_item_next;
      list_length <= LEN_W'(count);
      status      <= status_next;
      last        <= last_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_idle_no_move: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend)
    else $error("entry move pending while idle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1))))
    else $error("list count changed by more than one");

  a_dump_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_RD) |-> (CW'(k) < count))
    else $error("dump read beyond list end");

endmodule
